>>> design/sacm_pkg.sv
package sacm_pkg;

  // Default cache geometry. LINE_SIZE and SET_COUNT must be powers of two.
  localparam int unsigned DEF_LINE_SIZE    = 64;
  localparam int unsigned DEF_SET_COUNT    = 32;
  localparam int unsigned DEF_WAY_COUNT    = 4;
  localparam int unsigned DEF_ADDRESS_BITS = 32;

  // Fixed widths of the stream payloads.
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned MISS_CNT_W  = 32;
  localparam int unsigned OUT_FIELD_W = 2 + MISS_CNT_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [MISS_CNT_W-1:0] miss_cnt_t;

endpackage

>>> design/sacm_ram.sv
module sacm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/set_assoc_lru_cache_model.sv
// Pipeline: an accepted address is registered with its tag memory read (input register),
// then looked up and registered in the result register.
// Throughput: one address per cycle unless the result side stalls. Tag memory is read on
// accept, written on commit of a miss, with a bypass for back-to-back accesses to one set.
// Reset clears all valid bits, the LRU order of every set and the miss counter at once;
// tags are not cleared, since an invalid way is never compared. No clearing pass.
module set_assoc_lru_cache_model #(
  parameter int unsigned LINE_SIZE    = sacm_pkg::DEF_LINE_SIZE,
  parameter int unsigned SET_COUNT    = sacm_pkg::DEF_SET_COUNT,
  parameter int unsigned WAY_COUNT    = sacm_pkg::DEF_WAY_COUNT,
  parameter int unsigned ADDRESS_BITS = sacm_pkg::DEF_ADDRESS_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sacm_pkg::IN_DATA_W-1:0]  in_tdata,   // byte_address
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sacm_pkg::OUT_DATA_W-1:0] out_tdata   // hit, evicted, miss_total, zero pad
);

  import sacm_pkg::*;

  localparam int unsigned OFF_BITS = $clog2(LINE_SIZE);
  localparam int unsigned SET_BITS = $clog2(SET_COUNT);
  localparam int unsigned EFF_BITS = (ADDRESS_BITS < IN_DATA_W) ? ADDRESS_BITS : IN_DATA_W;
  localparam int unsigned TAG_W    = EFF_BITS - OFF_BITS - SET_BITS;
  localparam int unsigned IDX_W    = (SET_COUNT > 1) ? SET_BITS : 1;
  localparam int unsigned WAY_W    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned ROW_W    = TAG_W * WAY_COUNT;
  localparam int unsigned PAD_W    = OUT_DATA_W - OUT_FIELD_W;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [WAY_W-1:0] rank_t;
  typedef logic [ROW_W-1:0] row_t;

  // Per-set state kept in flip-flops so reset can clear it at once.
  logic [WAY_COUNT-1:0] valid_r [SET_COUNT];
  rank_t                rank_r  [SET_COUNT][WAY_COUNT];
  miss_cnt_t            miss_cnt_r;

  // Lookup stage.
  logic s1_valid_r;
  idx_t s1_set_r;
  tag_t s1_tag_r;
  logic fwd_r;
  row_t fwd_row_r;

  // Result register.
  logic      out_valid_r;
  logic      hit_r;
  logic      evict_r;
  miss_cnt_t total_r;

  logic accept;
  logic commit;
  idx_t in_set;
  tag_t in_tag;
  row_t ram_rdata;
  row_t cur_row;
  row_t new_row;
  logic ram_we;

  logic [WAY_COUNT-1:0] cur_valid;
  logic [WAY_COUNT-1:0] match;
  logic                 s1_hit;
  logic                 s1_evict;
  logic                 found_free;
  rank_t                hit_way;
  rank_t                free_way;
  rank_t                lru_way;
  rank_t                touch_way;
  rank_t                old_rank;
  rank_t                cur_rank [WAY_COUNT];
  rank_t                rank_nxt [WAY_COUNT];
  miss_cnt_t            miss_cnt_nxt;

  assign commit    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || commit;
  assign accept    = in_tvalid && in_tready;

  assign in_set = idx_t'((in_tdata >> OFF_BITS) & IN_DATA_W'(SET_COUNT - 1));
  assign in_tag = tag_t'(in_tdata >> (OFF_BITS + SET_BITS));

  sacm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT),
    .ADDR_W(IDX_W)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_set_r),
    .wdata(new_row),
    .re   (accept),
    .raddr(in_set),
    .rdata(ram_rdata)
  );

  // A read on the same edge as a write to that set would see the old row.
  assign cur_row = fwd_r ? fwd_row_r : ram_rdata;

  always_comb begin
    cur_valid  = valid_r[s1_set_r];
    match      = '0;
    hit_way    = '0;
    free_way   = '0;
    lru_way    = '0;
    s1_hit     = 1'b0;
    found_free = 1'b0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      cur_rank[w] = rank_r[s1_set_r][w];
      match[w]    = cur_valid[w] && (cur_row[w*TAG_W +: TAG_W] == s1_tag_r);
    end
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (match[w]) begin
        s1_hit  = 1'b1;
        hit_way = rank_t'(w);
      end
      if (!cur_valid[w]) begin
        found_free = 1'b1;
        free_way   = rank_t'(w);
      end
      // The ranks of a set are always a permutation, so the oldest is unique.
      if (cur_rank[w] == rank_t'(WAY_COUNT - 1)) begin
        lru_way = rank_t'(w);
      end
    end
    s1_evict  = !s1_hit && !found_free;
    touch_way = s1_hit ? hit_way : (found_free ? free_way : lru_way);
    old_rank  = cur_rank[touch_way];
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (rank_t'(w) == touch_way) begin
        rank_nxt[w] = '0;
      end else if (cur_rank[w] < old_rank) begin
        rank_nxt[w] = cur_rank[w] + rank_t'(1);
      end else begin
        rank_nxt[w] = cur_rank[w];
      end
    end
    new_row = cur_row;
    new_row[touch_way*TAG_W +: TAG_W] = s1_tag_r;
    if (s1_hit || (miss_cnt_r == '1)) begin
      miss_cnt_nxt = miss_cnt_r;
    end else begin
      miss_cnt_nxt = miss_cnt_r + miss_cnt_t'(1);
    end
  end

  assign ram_we = commit && !s1_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      miss_cnt_r  <= '0;
      for (int s = 0; s < SET_COUNT; s++) begin
        valid_r[s] <= '0;
        for (int w = 0; w < WAY_COUNT; w++) begin
          rank_r[s][w] <= rank_t'(w);
        end
      end
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= ram_we && (s1_set_r == in_set);
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        miss_cnt_r  <= miss_cnt_nxt;
        for (int w = 0; w < WAY_COUNT; w++) begin
          rank_r[s1_set_r][w] <= rank_nxt[w];
        end
        if (!s1_hit) begin
          valid_r[s1_set_r][touch_way] <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_set_r <= in_set;
      s1_tag_r <= in_tag;
    end
    if (ram_we) begin
      fwd_row_r <= new_row;
    end
    if (commit) begin
      hit_r   <= s1_hit;
      evict_r <= s1_evict;
      total_r <= miss_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), total_r, evict_r, hit_r};

  // A line is held in at most one way of its set.
  assert property (@(posedge clk) disable iff (!rst_n)
    commit && s1_hit |-> $countones(match) == 1)
    else $error("tag present in more than one way");

  // Each miss advances the counter by one until it saturates.
  assert property (@(posedge clk) disable iff (!rst_n)
    commit && !s1_hit |=> (miss_cnt_r == $past(miss_cnt_r) + miss_cnt_t'(1)) ||
                          ($past(miss_cnt_r) == '1 && miss_cnt_r == '1))
    else $error("miss counter did not advance on a miss");

  // The input side only stalls behind a full result register that is not drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without back-pressure");

  // An eviction only happens when every way of the set was valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    commit && s1_evict |-> cur_valid == '1)
    else $error("eviction with a free way");

endmodule

>>> dv/lru_cache_checker.sv
module lru_cache_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [sacm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sacm_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending,
  output int                              result_count,
  output int                              hit_count,
  output int                              evict_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import sacm_pkg::*;

  localparam int OFFSET_W = $clog2(DEF_LINE_SIZE);
  localparam int SET_W    = $clog2(DEF_SET_COUNT);
  localparam int TAG_W    = DEF_ADDRESS_BITS - OFFSET_W - SET_W;
  localparam int SETS     = DEF_SET_COUNT;
  localparam int WAYS     = DEF_WAY_COUNT;

  typedef struct packed {
    logic      hit;
    logic      evicted;
    miss_cnt_t miss_total;
  } access_result_t;

  logic [TAG_W-1:0] line_tag [SETS][WAYS];
  logic             line_valid [SETS][WAYS];
  int               age_rank [SETS][WAYS];
  miss_cnt_t        misses;
  access_result_t   expected_results[$];
  int               errors = 0;

  // Rank 0 is the most recent way; every way that was younger than the
  // touched one ages by one step.
  function automatic void touch_way(input int s, input int w);
    int old;
    int i;
    old = age_rank[s][w];
    for (i = 0; i < WAYS; i++) begin
      if (age_rank[s][i] < old) age_rank[s][i]++;
    end
    age_rank[s][w] = 0;
  endfunction

  function automatic access_result_t access_cache(input logic [DEF_ADDRESS_BITS-1:0] addr);
    logic [TAG_W-1:0] tag;
    int               s;
    int               w;
    int               victim;
    access_result_t   r;
    tag    = addr[DEF_ADDRESS_BITS-1 -: TAG_W];
    s      = int'(addr[OFFSET_W +: SET_W]);
    victim = -1;
    r      = '0;
    for (w = 0; w < WAYS; w++) begin
      if (line_valid[s][w] && line_tag[s][w] == tag) victim = w;
    end
    if (victim >= 0) begin
      touch_way(s, victim);
      r.hit        = 1'b1;
      r.miss_total = misses;
      return r;
    end
    if (misses != '1) misses++;
    for (w = WAYS - 1; w >= 0; w--) begin
      if (!line_valid[s][w]) victim = w;
    end
    if (victim < 0) begin
      // The set is full: replace the way with the oldest rank.
      victim = 0;
      for (w = 0; w < WAYS; w++) begin
        if (age_rank[s][w] > age_rank[s][victim]) victim = w;
      end
      r.evicted = 1'b1;
    end
    line_tag[s][victim]   = tag;
    line_valid[s][victim] = 1'b1;
    touch_way(s, victim);
    r.miss_total = misses;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          age_rank[s][w]   = w;
        end
      end
      misses = '0;
      expected_results.delete();
      result_count <= 0;
      hit_count    <= 0;
      evict_count  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: result transfer with none expected, actual 0x%0h", $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 64'(want.hit), 64'(out_tdata[0]));
          check_field("evicted", 64'(want.evicted), 64'(out_tdata[1]));
          check_field("miss_total", 64'(want.miss_total), 64'(out_tdata[2 +: MISS_CNT_W]));
          check_field("pad", 64'(0), 64'(out_tdata[OUT_DATA_W-1:OUT_FIELD_W]));
          result_count <= result_count + 1;
          if (want.hit) hit_count <= hit_count + 1;
          if (want.evicted) evict_count <= evict_count + 1;
        end
      end
      if (in_tvalid && in_tready) expected_results.push_back(access_cache(in_tdata));
    end
    pending    <= expected_results.size();
    fail_count <= errors;
  end

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sacm_pkg::*;

  localparam int OFFSET_W     = $clog2(DEF_LINE_SIZE);
  localparam int SET_W        = $clog2(DEF_SET_COUNT);
  localparam int TAG_W        = DEF_ADDRESS_BITS - OFFSET_W - SET_W;
  localparam int RANDOM_ITEMS = 1630;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // byte_address
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // hit, evicted, miss_total, zero pad

  int fail_count;
  int pending;
  int result_count;
  int hit_count;
  int evict_count;

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  bit hold_go  = 1'b0;

  int tag_pool [6];
  int hot_sets [4];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  set_assoc_lru_cache_model dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lru_cache_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .hit_count    (hit_count),
    .evict_count  (evict_count)
  );

  function automatic logic [IN_DATA_W-1:0] line_addr(input int tag, input int s, input int off);
    return {tag[TAG_W-1:0], s[SET_W-1:0], off[OFFSET_W-1:0]};
  endfunction

  // Mostly reuse a small pool of tags, often on a few busy sets, so that sets fill up,
  // hit and evict; one access in ten is a fully random address.
  function automatic logic [IN_DATA_W-1:0] pick_address();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom();
    s = (r < 55) ? hot_sets[$urandom_range(0, 3)] : $urandom_range(0, DEF_SET_COUNT - 1);
    return line_addr(tag_pool[$urandom_range(0, 5)], s, $urandom_range(0, DEF_LINE_SIZE - 1));
  endfunction

  task automatic send_access(input logic [IN_DATA_W-1:0] addr);
    in_tdata  <= addr;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  initial begin : result_side
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_go && !held) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [IN_DATA_W-1:0] directed [$];
    int i;
    for (i = 0; i < 6; i++) tag_pool[i] = $urandom();
    for (i = 0; i < 4; i++) hot_sets[i] = $urandom_range(0, DEF_SET_COUNT - 1);

    // Set 0 is filled through its free ways, then driven through LRU evictions.
    directed = '{
      line_addr(0, 0, 0), 32'h0000_003F, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
      line_addr(1, 0, 5), line_addr(2, 0, 9), line_addr(3, 0, 63), line_addr(0, 0, 1),
      line_addr(4, 0, 0), line_addr(1, 0, 0), line_addr(3, 0, 0), line_addr(5, 0, 0),
      32'h8000_0000, line_addr(0, DEF_SET_COUNT - 1, 0), 32'h5555_5555, 32'hAAAA_AAAA,
      32'h5555_5555, line_addr(-1, 0, 0)
    };

    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gaps_on = 1'b0;
    foreach (directed[k]) send_access(directed[k]);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        gaps_on  = ($urandom_range(0, 2) != 0);
        stall_on = ($urandom_range(0, 2) != 0);
      end
      if (i >= RANDOM_ITEMS - 200) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      if (i == 300) begin
        // Keep offering while the result side holds off, so the pipe backs up.
        hold_go = 1'b1;
        gaps_on = 1'b0;
      end
      if (i == 800) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (i % 64 == 0) tag_pool[$urandom_range(0, 5)] = $urandom();
      send_access(pick_address());
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);

    $display("Covered %0d accesses: %0d hits, %0d misses, %0d evictions.",
             result_count, hit_count, result_count - hit_count, evict_count);
    $display("Included a long result-side hold-off and a full drain mid-run.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
